/* hdl/dlr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dlr_pkg: shared types and constants of the dotted line rasterizer
// Request and result payloads, the command word passed from the front end
// to the step engine, and the widths derived from the coordinate width.
// ----------------------------------------------------------------------------
package dlr_pkg;

  localparam int COORD_WIDTH = 11;
  localparam int DELTA_W     = COORD_WIDTH + 1;
  localparam int ERR_W       = COORD_WIDTH + 3;
  localparam int PITCH_W     = 12;
  localparam int ADDR_W      = 22;
  localparam int COLOUR_W    = 8;
  localparam int DASH_W      = 3;
  localparam int DASH_BIT    = 2;

  localparam logic [PITCH_W-1:0] PITCH_RESET = PITCH_W'(1024);

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic REQ_START   = 1'b0;
  localparam logic REQ_ADVANCE = 1'b1;

  typedef struct packed {
    logic                   req_type;
    logic [COORD_WIDTH-1:0] start_x;
    logic [COORD_WIDTH-1:0] start_y;
    logic [COORD_WIDTH-1:0] end_x;
    logic [COORD_WIDTH-1:0] end_y;
    logic                   dotted;
    logic [COLOUR_W-1:0]    colour;
  } req_t;

  typedef struct packed {
    logic                   write_enable;
    logic [COORD_WIDTH-1:0] pixel_x;
    logic [COORD_WIDTH-1:0] pixel_y;
    logic [ADDR_W-1:0]      pixel_address;
    logic [COLOUR_W-1:0]    pixel_colour;
    logic                   last;
    logic                   busy_res;
  } res_t;

  // Command word: a start carries the full line setup; for an advance the engine reads only its kind.
  typedef struct packed {
    logic                   kind;
    logic [COORD_WIDTH-1:0] cur_x;
    logic [COORD_WIDTH-1:0] cur_y;
    logic [COORD_WIDTH-1:0] stop_x;
    logic [COORD_WIDTH-1:0] stop_y;
    logic [DELTA_W-1:0]     delta_x;
    logic [DELTA_W-1:0]     delta_y_neg;
    logic                   step_x_neg;
    logic                   step_y_neg;
    logic [ERR_W-1:0]       error_term;
    logic                   dotted;
    logic [COLOUR_W-1:0]    colour;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage
`default_nettype wire

/* hdl/dlr_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dlr_front: request intake and line setup
// Accepts requests while the queue has room, classifies them and computes
// deltas, step directions and initial error, which only a start request uses.
// ----------------------------------------------------------------------------
module dlr_front (
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire dlr_pkg::req_t      in_req,
  input  wire dlr_pkg::q_status_t q_status,
  output logic                    push,
  output dlr_pkg::cmd_t           push_cmd
);
  import dlr_pkg::*;

  logic [COORD_WIDTH-1:0] abs_dx;
  logic [COORD_WIDTH-1:0] abs_dy;
  logic [DELTA_W-1:0]     dx;
  logic [DELTA_W-1:0]     dy_neg;

  assign in_ready = !q_status.full;
  assign push     = in_valid && in_ready;

  assign abs_dx = (in_req.end_x > in_req.start_x) ? in_req.end_x - in_req.start_x
                                                  : in_req.start_x - in_req.end_x;
  assign abs_dy = (in_req.end_y > in_req.start_y) ? in_req.end_y - in_req.start_y
                                                  : in_req.start_y - in_req.end_y;
  assign dx     = DELTA_W'(abs_dx);
  assign dy_neg = DELTA_W'(0) - DELTA_W'(abs_dy);

  always_comb begin
    push_cmd             = '0;
    push_cmd.kind        = in_req.req_type;
    push_cmd.cur_x       = in_req.start_x;
    push_cmd.cur_y       = in_req.start_y;
    push_cmd.stop_x      = in_req.end_x;
    push_cmd.stop_y      = in_req.end_y;
    push_cmd.delta_x     = dx;
    push_cmd.delta_y_neg = dy_neg;
    push_cmd.step_x_neg  = !(in_req.start_x < in_req.end_x);
    push_cmd.step_y_neg  = !(in_req.start_y < in_req.end_y);
    push_cmd.error_term  = ERR_W'($signed(dx)) + ERR_W'($signed(dy_neg));
    push_cmd.dotted      = in_req.dotted;
    push_cmd.colour      = in_req.colour;
  end

endmodule
`default_nettype wire

/* hdl/dlr_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dlr_queue: command queue between front end and step engine
// Small circular buffer; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module dlr_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire dlr_pkg::cmd_t      push_cmd,
  input  wire logic               pop,
  output dlr_pkg::cmd_t           pop_cmd,
  output dlr_pkg::q_status_t      q_status
);
  import dlr_pkg::*;

  cmd_t                   entry_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r;
  logic [QUEUE_PTR_W-1:0] wr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r;
  logic [QUEUE_PTR_W-1:0] rd_ptr_nxt;
  logic [QUEUE_CNT_W-1:0] count_r;
  logic [QUEUE_CNT_W-1:0] count_nxt;
  logic                   do_push;
  logic                   do_pop;

  assign q_status.full  = (count_r == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign q_status.empty = (count_r == '0);
  assign do_push        = push && !q_status.full;
  assign do_pop         = pop && !q_status.empty;
  assign pop_cmd        = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

/* hdl/dlr_engine.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dlr_engine: Bresenham step engine
// Pops one command per cycle unless the pending result stalls: a start loads
// the line state, an advance registers the current pixel and steps toward the end.
// ----------------------------------------------------------------------------
module dlr_engine (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire dlr_pkg::q_status_t             q_status,
  input  wire dlr_pkg::cmd_t                  pop_cmd,
  output logic                                pop,
  input  wire logic                           cfg_write_en,
  input  wire logic [dlr_pkg::PITCH_W-1:0]    cfg_write_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output dlr_pkg::res_t                       out_res
);
  import dlr_pkg::*;

  logic [PITCH_W-1:0]     row_pitch_r;
  logic [COORD_WIDTH-1:0] cur_x_r, cur_x_nxt;
  logic [COORD_WIDTH-1:0] cur_y_r, cur_y_nxt;
  logic [COORD_WIDTH-1:0] stop_x_r, stop_x_nxt;
  logic [COORD_WIDTH-1:0] stop_y_r, stop_y_nxt;
  logic [DELTA_W-1:0]     delta_x_r, delta_x_nxt;
  logic [DELTA_W-1:0]     delta_y_neg_r, delta_y_neg_nxt;
  logic                   step_x_neg_r, step_x_neg_nxt;
  logic                   step_y_neg_r, step_y_neg_nxt;
  logic [ERR_W-1:0]       error_term_r, error_term_nxt;
  logic [DASH_W-1:0]      dash_count_r, dash_count_nxt;
  logic                   dotted_mode_r, dotted_mode_nxt;
  logic [COLOUR_W-1:0]    line_colour_r, line_colour_nxt;
  logic                   active_r, active_nxt;
  logic                   out_valid_r, out_valid_nxt;
  res_t                   out_res_r, out_res_nxt;

  logic                   is_advance;
  logic                   at_end;
  logic                   draw;
  logic [ADDR_W-1:0]      addr;
  logic signed [ERR_W:0]  e2;
  logic signed [ERR_W:0]  dx_ext;
  logic signed [ERR_W:0]  dyn_ext;
  logic                   move_x;
  logic                   move_y;

  assign pop        = !q_status.empty && (!out_valid_r || out_ready);
  assign is_advance = (pop_cmd.kind == REQ_ADVANCE);
  assign at_end     = (cur_x_r == stop_x_r) && (cur_y_r == stop_y_r);
  assign draw       = !dotted_mode_r || dash_count_r[DASH_BIT];
  assign addr       = ADDR_W'(cur_x_r) + ADDR_W'(cur_y_r) * ADDR_W'(row_pitch_r);

  assign e2      = {error_term_r[ERR_W-1], error_term_r} <<< 1;
  assign dx_ext  = (ERR_W+1)'(delta_x_r);
  assign dyn_ext = (ERR_W+1)'($signed(delta_y_neg_r));
  assign move_x  = (e2 >= dyn_ext);
  assign move_y  = (e2 <= dx_ext);

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_comb begin
    cur_x_nxt       = cur_x_r;
    cur_y_nxt       = cur_y_r;
    stop_x_nxt      = stop_x_r;
    stop_y_nxt      = stop_y_r;
    delta_x_nxt     = delta_x_r;
    delta_y_neg_nxt = delta_y_neg_r;
    step_x_neg_nxt  = step_x_neg_r;
    step_y_neg_nxt  = step_y_neg_r;
    error_term_nxt  = error_term_r;
    dash_count_nxt  = dash_count_r;
    dotted_mode_nxt = dotted_mode_r;
    line_colour_nxt = line_colour_r;
    active_nxt      = active_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_res_nxt     = out_res_r;

    if (pop && !is_advance) begin
      // restart unconditionally, even over a line still in flight
      cur_x_nxt       = pop_cmd.cur_x;
      cur_y_nxt       = pop_cmd.cur_y;
      stop_x_nxt      = pop_cmd.stop_x;
      stop_y_nxt      = pop_cmd.stop_y;
      delta_x_nxt     = pop_cmd.delta_x;
      delta_y_neg_nxt = pop_cmd.delta_y_neg;
      step_x_neg_nxt  = pop_cmd.step_x_neg;
      step_y_neg_nxt  = pop_cmd.step_y_neg;
      error_term_nxt  = pop_cmd.error_term;
      dash_count_nxt  = '0;
      dotted_mode_nxt = pop_cmd.dotted;
      line_colour_nxt = pop_cmd.colour;
      active_nxt      = 1'b1;
    end else if (pop) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = '0;
      if (active_r) begin
        dash_count_nxt            = dash_count_r + 1'b1;
        out_res_nxt.write_enable  = draw;
        out_res_nxt.pixel_x       = cur_x_r;
        out_res_nxt.pixel_y       = cur_y_r;
        out_res_nxt.pixel_address = addr;
        out_res_nxt.pixel_colour  = line_colour_r;
        out_res_nxt.last          = at_end;
        out_res_nxt.busy_res      = !at_end;
        if (at_end) begin
          active_nxt = 1'b0;
        end else begin
          error_term_nxt = error_term_r
                         + (move_x ? ERR_W'($signed(delta_y_neg_r)) : ERR_W'(0))
                         + (move_y ? ERR_W'(delta_x_r) : ERR_W'(0));
          if (move_x) begin
            cur_x_nxt = step_x_neg_r ? cur_x_r - 1'b1 : cur_x_r + 1'b1;
          end
          if (move_y) begin
            cur_y_nxt = step_y_neg_r ? cur_y_r - 1'b1 : cur_y_r + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_pitch_r   <= PITCH_RESET;
      cur_x_r       <= '0;
      cur_y_r       <= '0;
      stop_x_r      <= '0;
      stop_y_r      <= '0;
      delta_x_r     <= '0;
      delta_y_neg_r <= '0;
      step_x_neg_r  <= 1'b0;
      step_y_neg_r  <= 1'b0;
      error_term_r  <= '0;
      dash_count_r  <= '0;
      dotted_mode_r <= 1'b0;
      line_colour_r <= '0;
      active_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        row_pitch_r <= cfg_write_data;
      end
      cur_x_r       <= cur_x_nxt;
      cur_y_r       <= cur_y_nxt;
      stop_x_r      <= stop_x_nxt;
      stop_y_r      <= stop_y_nxt;
      delta_x_r     <= delta_x_nxt;
      delta_y_neg_r <= delta_y_neg_nxt;
      step_x_neg_r  <= step_x_neg_nxt;
      step_y_neg_r  <= step_y_neg_nxt;
      error_term_r  <= error_term_nxt;
      dash_count_r  <= dash_count_nxt;
      dotted_mode_r <= dotted_mode_nxt;
      line_colour_r <= line_colour_nxt;
      active_r      <= active_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  a_start_arms: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !is_advance |=> active_r)
    else $error("start request did not arm the engine");

  a_end_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    pop && is_advance && active_r && at_end |=> !active_r && out_valid_r && out_res_r.last)
    else $error("end pixel did not finish the line");

  a_last_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_res_r.last && out_res_r.busy_res))
    else $error("result flagged both last and busy");

  a_write_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.write_enable |-> out_res_r.busy_res || out_res_r.last)
    else $error("pixel write outside an active line");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !pop)
    else $error("pending result would be overwritten");

endmodule
`default_nettype wire

/* hdl/dotted_line_rasterizer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dotted_line_rasterizer: all-octant Bresenham line engine with dotted mode
//
// A start request (req_type 0) loads both endpoints, the colour and the
// dotted flag and produces no result. Each advance request (req_type 1)
// produces exactly one result: the current pixel, its linear address
// x + y * row_pitch, the colour and a last flag; the engine then steps one
// pixel. In dotted mode pixels come out four skipped, four written. An
// advance with no line active returns an all-zero result.
// Both channels are valid/ready. Requests go through a four-entry command
// queue to the step engine, which retires one request per cycle while its
// output register is free or being taken; an accepted advance is held in a
// queue entry and then in the output register before its result shows.
// When the receiver stalls the result is held in the output register, the
// queue fills and in_ready drops after four more requests. row_pitch is
// written through cfg_write_en and cfg_write_data; the user must write it
// only while idle, and the block does not enforce this. Synchronous reset
// empties the queue, idles the engine and sets row_pitch to 1024.
// ----------------------------------------------------------------------------
module dotted_line_rasterizer (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire dlr_pkg::req_t               in_req,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output dlr_pkg::res_t                    out_res,
  input  wire logic                        cfg_write_en,
  input  wire logic [dlr_pkg::PITCH_W-1:0] cfg_write_data
);
  import dlr_pkg::*;

  q_status_t q_status;
  cmd_t      push_cmd;
  cmd_t      pop_cmd;
  logic      push;
  logic      pop;

  dlr_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_req   (in_req),
    .q_status (q_status),
    .push     (push),
    .push_cmd (push_cmd)
  );

  dlr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .q_status (q_status)
  );

  dlr_engine u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_status       (q_status),
    .pop_cmd        (pop_cmd),
    .pop            (pop),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_res        (out_res)
  );

endmodule
`default_nettype wire
